/* rtl/sgrc_pkg.sv */
`timescale 1ns / 1ps

package sgrc_pkg;

    localparam int MAX_SEGMENTS_DEF = 16;

    // result status codes
    typedef enum logic [1:0] {
        ST_CHUNK   = 2'd0,
        ST_ACK     = 2'd1,
        ST_INVALID = 2'd2,
        ST_EMPTY   = 2'd3
    } t_status;

    // request kinds
    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_XFER = 1'b1;

endpackage

/* rtl/scatter_gather_read_chunker.sv */
`timescale 1ns / 1ps

// Scatter-gather read chunker.
// Input channel (i_in_valid / o_in_ready) takes two kinds of request. A load
// writes one segment entry (address, size) into the table; with seg_is_last
// set the segment count becomes seg_index + 1. Every load returns one
// acknowledge result. A transfer gives a byte offset into the concatenated
// segments and a length; the block returns one chunk per non-empty segment
// touched (last set on the final one), or a single invalid / empty result.
// Output channel (o_out_valid / i_out_ready) is a single result register; the
// sequencer holds when that register is full and not being taken.
// Timing: a load's acknowledge is registered and appears in the cycle after it is accepted.
// A transfer keeps o_in_ready low while the sequencer works: for each segment
// examined by the seek, a table read and then a compare (S_SEEK_RD, S_SEEK);
// the segment that holds the offset goes straight on to S_WALK; each further
// segment walked takes a read and a compare (S_WALK_RD, S_WALK); then S_FLUSH
// sends the final chunk. The registered table read sets this pace; receiver
// stalls add to it. One request is handled at a time.
// Reset clears the segment count and the sequencer; table contents are kept
// undefined until loaded.

module scatter_gather_read_chunker #(
    parameter int MAX_SEGMENTS = sgrc_pkg::MAX_SEGMENTS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic              i_req_type,
    input  logic [3:0]        i_seg_index,
    input  logic [31:0]       i_seg_addr,
    input  logic [31:0]       i_seg_size,
    input  logic              i_seg_is_last,
    input  logic [31:0]       i_start_offset,
    input  logic [31:0]       i_transfer_length,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output sgrc_pkg::t_status o_status,
    output logic [3:0]        o_chunk_seg,
    output logic [31:0]       o_chunk_src_addr,
    output logic [31:0]       o_chunk_dst_offset,
    output logic [31:0]       o_chunk_len,
    output logic              o_last
);

    import sgrc_pkg::*;

    localparam int IDX_W = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
    localparam int CMP_W = (IDX_W + 1 > 5) ? IDX_W + 1 : 5;

    typedef enum logic [5:0] {
        S_IDLE    = 6'b000001,
        S_SEEK_RD = 6'b000010,
        S_SEEK    = 6'b000100,
        S_WALK_RD = 6'b001000,
        S_WALK    = 6'b010000,
        S_FLUSH   = 6'b100000
    } t_state;

    t_state           r_state, n_state;
    logic [4:0]       r_count, n_count;
    logic [IDX_W-1:0] r_idx, n_idx;
    logic [31:0]      r_pos, n_pos;
    logic [31:0]      r_rem, n_rem;
    logic [31:0]      r_emitted, n_emitted;
    logic             r_have_pend, n_have_pend;
    logic [IDX_W-1:0] r_pend_seg, n_pend_seg;
    logic [31:0]      r_pend_src, n_pend_src;
    logic [31:0]      r_pend_dst, n_pend_dst;
    logic [31:0]      r_pend_len, n_pend_len;

    logic             r_o_valid, n_o_valid;
    t_status          r_status, n_status;
    logic [3:0]       r_seg, n_seg;
    logic [31:0]      r_src, n_src;
    logic [31:0]      r_dst, n_dst;
    logic [31:0]      r_len, n_len;
    logic             r_last, n_last;

    logic             can_push;
    logic             accept;
    logic             tbl_we;
    logic [IDX_W-1:0] tbl_waddr;
    logic [31:0]      rd_size;
    logic [31:0]      rd_addr;
    logic [CMP_W-1:0] cnt_eff;
    logic             at_end;
    logic [31:0]      seg_left;
    logic             fits;
    logic [31:0]      take;

    assign can_push   = !r_o_valid || i_out_ready;
    assign o_in_ready = (r_state == S_IDLE) && can_push;
    assign accept     = i_in_valid && o_in_ready;

    assign tbl_waddr = IDX_W'(i_seg_index);
    assign tbl_we    = accept && (i_req_type == REQ_LOAD)
                       && (CMP_W'(i_seg_index) < CMP_W'(MAX_SEGMENTS));

    sgrc_ram #(.WIDTH(32), .DEPTH(MAX_SEGMENTS)) u_addr_ram (
        .i_clk   (i_clk),
        .i_we    (tbl_we),
        .i_waddr (tbl_waddr),
        .i_wdata (i_seg_addr),
        .i_raddr (r_idx),
        .o_rdata (rd_addr)
    );

    sgrc_ram #(.WIDTH(32), .DEPTH(MAX_SEGMENTS)) u_size_ram (
        .i_clk   (i_clk),
        .i_we    (tbl_we),
        .i_waddr (tbl_waddr),
        .i_wdata (i_seg_size),
        .i_raddr (r_idx),
        .o_rdata (rd_size)
    );

    assign cnt_eff  = (CMP_W'(r_count) > CMP_W'(MAX_SEGMENTS)) ? CMP_W'(MAX_SEGMENTS)
                                                              : CMP_W'(r_count);
    assign at_end   = (CMP_W'(r_idx) + CMP_W'(1)) == cnt_eff;
    assign seg_left = rd_size - r_pos;
    // rem <= seg_left means this chunk finishes the request
    assign fits     = r_rem <= seg_left;
    assign take     = fits ? r_rem : seg_left;

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_idx       = r_idx;
        n_pos       = r_pos;
        n_rem       = r_rem;
        n_emitted   = r_emitted;
        n_have_pend = r_have_pend;
        n_pend_seg  = r_pend_seg;
        n_pend_src  = r_pend_src;
        n_pend_dst  = r_pend_dst;
        n_pend_len  = r_pend_len;
        n_o_valid   = r_o_valid && !i_out_ready;
        n_status    = r_status;
        n_seg       = r_seg;
        n_src       = r_src;
        n_dst       = r_dst;
        n_len       = r_len;
        n_last      = r_last;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_req_type == REQ_LOAD) begin
                        if (tbl_we && i_seg_is_last) begin
                            n_count = 5'(i_seg_index) + 5'd1;
                        end
                        n_o_valid = 1'b1;
                        n_status  = ST_ACK;
                        n_seg     = i_seg_index;
                        n_src     = '0;
                        n_dst     = '0;
                        n_len     = '0;
                        n_last    = 1'b1;
                    end else if (cnt_eff == '0) begin
                        n_o_valid = 1'b1;
                        n_status  = ST_INVALID;
                        n_seg     = '0;
                        n_src     = '0;
                        n_dst     = '0;
                        n_len     = '0;
                        n_last    = 1'b1;
                    end else begin
                        n_idx       = '0;
                        n_pos       = i_start_offset;
                        n_rem       = i_transfer_length;
                        n_emitted   = '0;
                        n_have_pend = 1'b0;
                        n_state     = S_SEEK_RD;
                    end
                end
            end
            S_SEEK_RD: begin
                n_state = S_SEEK;
            end
            S_SEEK: begin
                // r_pos holds the offset left after the segments passed so far
                if (r_pos < rd_size) begin
                    if (r_rem == '0) begin
                        if (can_push) begin
                            n_o_valid = 1'b1;
                            n_status  = ST_EMPTY;
                            n_seg     = '0;
                            n_src     = '0;
                            n_dst     = '0;
                            n_len     = '0;
                            n_last    = 1'b1;
                            n_state   = S_IDLE;
                        end
                    end else begin
                        n_state = S_WALK;
                    end
                end else if (at_end) begin
                    if (can_push) begin
                        n_o_valid = 1'b1;
                        n_status  = ST_INVALID;
                        n_seg     = '0;
                        n_src     = '0;
                        n_dst     = '0;
                        n_len     = '0;
                        n_last    = 1'b1;
                        n_state   = S_IDLE;
                    end
                end else begin
                    n_pos   = r_pos - rd_size;
                    n_idx   = r_idx + IDX_W'(1);
                    n_state = S_SEEK_RD;
                end
            end
            S_WALK_RD: begin
                n_state = S_WALK;
            end
            S_WALK: begin
                if (seg_left != '0) begin
                    if (!(r_have_pend && !can_push)) begin
                        // previous chunk has a successor, so it is not last
                        if (r_have_pend) begin
                            n_o_valid = 1'b1;
                            n_status  = ST_CHUNK;
                            n_seg     = 4'(r_pend_seg);
                            n_src     = r_pend_src;
                            n_dst     = r_pend_dst;
                            n_len     = r_pend_len;
                            n_last    = 1'b0;
                        end
                        n_have_pend = 1'b1;
                        n_pend_seg  = r_idx;
                        n_pend_src  = rd_addr + r_pos;
                        n_pend_dst  = r_emitted;
                        n_pend_len  = take;
                        n_emitted   = r_emitted + take;
                        n_rem       = r_rem - take;
                        if (fits || at_end) begin
                            n_state = S_FLUSH;
                        end else begin
                            n_idx   = r_idx + IDX_W'(1);
                            n_pos   = '0;
                            n_state = S_WALK_RD;
                        end
                    end
                end else if (at_end) begin
                    n_state = S_FLUSH;
                end else begin
                    n_idx   = r_idx + IDX_W'(1);
                    n_pos   = '0;
                    n_state = S_WALK_RD;
                end
            end
            S_FLUSH: begin
                if (can_push) begin
                    n_o_valid   = 1'b1;
                    n_status    = ST_CHUNK;
                    n_seg       = 4'(r_pend_seg);
                    n_src       = r_pend_src;
                    n_dst       = r_pend_dst;
                    n_len       = r_pend_len;
                    n_last      = 1'b1;
                    n_have_pend = 1'b0;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_have_pend <= 1'b0;
            r_o_valid   <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_have_pend <= n_have_pend;
            r_o_valid   <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx      <= n_idx;
        r_pos      <= n_pos;
        r_rem      <= n_rem;
        r_emitted  <= n_emitted;
        r_pend_seg <= n_pend_seg;
        r_pend_src <= n_pend_src;
        r_pend_dst <= n_pend_dst;
        r_pend_len <= n_pend_len;
        r_status   <= n_status;
        r_seg      <= n_seg;
        r_src      <= n_src;
        r_dst      <= n_dst;
        r_len      <= n_len;
        r_last     <= n_last;
    end

    assign o_out_valid        = r_o_valid;
    assign o_status           = r_status;
    assign o_chunk_seg        = r_seg;
    assign o_chunk_src_addr   = r_src;
    assign o_chunk_dst_offset = r_dst;
    assign o_chunk_len        = r_len;
    assign o_last             = r_last;

    // non-chunk results always close their request
    a_status_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && r_status != ST_CHUNK) |-> r_last)
        else $error("non-chunk result without last");

    // emitted chunks never carry zero bytes
    a_chunk_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && r_status == ST_CHUNK) |-> (r_len != '0))
        else $error("zero-length chunk");

    // the walk only runs while bytes are still owed
    a_walk_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK || r_state == S_WALK_RD) |-> (r_rem != '0))
        else $error("walk with nothing remaining");

    // table index stays inside the active segments during a transfer
    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SEEK || r_state == S_WALK) |-> (CMP_W'(r_idx) < cnt_eff))
        else $error("table index past segment count");

    // the final chunk is flushed only with a pending chunk held
    a_flush_pend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FLUSH) |-> r_have_pend)
        else $error("flush without pending chunk");

endmodule

/* rtl/sgrc_ram.sv */
`timescale 1ns / 1ps

module sgrc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                                i_clk,
    input  logic                                i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                    i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                    o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* tb/sgrc_chunk_checker.sv */
`timescale 1ns / 1ps

module sgrc_chunk_checker (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_in_ready,
    input  logic              i_req_type,
    input  logic [3:0]        i_seg_index,
    input  logic [31:0]       i_seg_addr,
    input  logic [31:0]       i_seg_size,
    input  logic              i_seg_is_last,
    input  logic [31:0]       i_start_offset,
    input  logic [31:0]       i_transfer_length,
    input  logic              i_out_valid,
    input  logic              i_out_ready,
    input  sgrc_pkg::t_status i_status,
    input  logic [3:0]        i_chunk_seg,
    input  logic [31:0]       i_chunk_src_addr,
    input  logic [31:0]       i_chunk_dst_offset,
    input  logic [31:0]       i_chunk_len,
    input  logic              i_last,
    output int                o_errors,
    output int                o_pending
);
    import sgrc_pkg::*;

    localparam int SEG_SLOTS  = MAX_SEGMENTS_DEF;
    localparam int PRINT_CAP  = 100;

    typedef struct {
        t_status     status;
        logic [3:0]  seg;
        logic [31:0] src_addr;
        logic [31:0] dst_offset;
        logic [31:0] len;
        logic        last;
    } chunk_result_t;

    logic [31:0]   seg_addr_tab [SEG_SLOTS] = '{default: '0};
    logic [31:0]   seg_size_tab [SEG_SLOTS] = '{default: '0};
    logic [4:0]    seg_count = '0;
    chunk_result_t expected_results [$];
    int            mismatches = 0;
    int            pending_count = 0;

    assign o_errors  = mismatches;
    assign o_pending = pending_count;

    task automatic report_mismatch(input string what);
        if (mismatches < PRINT_CAP)
            $display("[%0t] MISMATCH: %s", $time, what);
        mismatches++;
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %h want %h", name, got, want));
    endtask

    // Works out the results of one accepted request and queues them.
    task automatic predict_request(input logic req, input logic [3:0] idx,
                                   input logic [31:0] addr, input logic [31:0] size,
                                   input logic is_last, input logic [31:0] off,
                                   input logic [31:0] len);
        chunk_result_t   r;
        chunk_result_t   walk [SEG_SLOTS];
        longint unsigned base;
        longint unsigned at;
        logic [31:0]     pos;
        logic [31:0]     seg_left;
        logic [31:0]     remaining;
        logic [31:0]     emitted;
        logic [31:0]     take;
        int              cnt;
        int              i;
        int              n;
        bit              found;

        r = '{status: ST_ACK, seg: idx, src_addr: '0, dst_offset: '0, len: '0,
              last: 1'b1};
        if (req == REQ_LOAD) begin
            if (int'(idx) < SEG_SLOTS) begin
                seg_addr_tab[idx] = addr;
                seg_size_tab[idx] = size;
                if (is_last)
                    seg_count = 5'(idx) + 5'd1;
            end
            expected_results.push_back(r);
            return;
        end

        cnt = (int'(seg_count) > SEG_SLOTS) ? SEG_SLOTS : int'(seg_count);
        base = 0;
        at = off;
        pos = '0;
        found = 1'b0;
        i = 0;
        // seek: empty segments never hold the offset
        while (i < cnt && !found) begin
            if (at >= base && at < base + seg_size_tab[i]) begin
                pos = 32'(at - base);
                found = 1'b1;
            end else begin
                base += seg_size_tab[i];
                i++;
            end
        end

        r.seg = '0;
        if (!found) begin
            r.status = ST_INVALID;
            expected_results.push_back(r);
            return;
        end
        if (len == 0) begin
            r.status = ST_EMPTY;
            expected_results.push_back(r);
            return;
        end

        remaining = len;
        emitted = '0;
        n = 0;
        while (i < cnt && remaining != 0) begin
            seg_left = seg_size_tab[i] - pos;
            if (seg_left != 0) begin
                take = (remaining < seg_left) ? remaining : seg_left;
                walk[n] = '{status: ST_CHUNK, seg: 4'(i), src_addr: seg_addr_tab[i] + pos,
                            dst_offset: emitted, len: take, last: 1'b0};
                n++;
                emitted += take;
                remaining -= take;
            end
            pos = '0;
            i++;
        end
        walk[n-1].last = 1'b1;
        for (int k = 0; k < n; k++)
            expected_results.push_back(walk[k]);
    endtask

    always @(posedge i_clk) begin
        chunk_result_t want;
        if (!i_rst_n) begin
            seg_count = '0;
            expected_results.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (expected_results.size() == 0) begin
                    report_mismatch($sformatf("result status %0d with nothing expected",
                                              i_status));
                end else begin
                    want = expected_results.pop_front();
                    check_field("status", 32'(i_status), 32'(want.status));
                    check_field("chunk_seg", 32'(i_chunk_seg), 32'(want.seg));
                    check_field("chunk_src_addr", i_chunk_src_addr, want.src_addr);
                    check_field("chunk_dst_offset", i_chunk_dst_offset, want.dst_offset);
                    check_field("chunk_len", i_chunk_len, want.len);
                    check_field("last", 32'(i_last), 32'(want.last));
                end
            end
            if (i_in_valid && i_in_ready)
                predict_request(i_req_type, i_seg_index, i_seg_addr, i_seg_size,
                                i_seg_is_last, i_start_offset, i_transfer_length);
        end
        pending_count = expected_results.size();
    end

endmodule

/* tb/scatter_gather_read_chunker_test.sv */
`timescale 1ns / 1ps

module scatter_gather_read_chunker_test;
    import sgrc_pkg::*;

    localparam int SEG_SLOTS    = MAX_SEGMENTS_DEF;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int ITEM_TARGET  = 130;
    localparam int LONG_HOLD    = 300;
    localparam int FLUSH_CYCLES = 80;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic        req_type = REQ_LOAD;
    logic [3:0]  seg_index = '0;
    logic [31:0] seg_addr = '0;
    logic [31:0] seg_size = '0;
    logic        seg_is_last = 1'b0;
    logic [31:0] start_offset = '0;
    logic [31:0] transfer_length = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    t_status     status;
    logic [3:0]  chunk_seg;
    logic [31:0] chunk_src_addr;
    logic [31:0] chunk_dst_offset;
    logic [31:0] chunk_len;
    logic        last;

    int          errors;
    int          pending;
    int          cycle_count = 0;
    int          items_sent = 0;
    bit          no_idle = 1'b0;

    // stimulus-side view of the table, used to aim offsets
    logic [31:0] shadow_size [SEG_SLOTS] = '{default: '0};
    int          shadow_count = 0;

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    scatter_gather_read_chunker DUT (
        .i_clk              (clk),
        .i_rst_n            (rst_n),
        .i_in_valid         (in_valid),
        .o_in_ready         (in_ready),
        .i_req_type         (req_type),
        .i_seg_index        (seg_index),
        .i_seg_addr         (seg_addr),
        .i_seg_size         (seg_size),
        .i_seg_is_last      (seg_is_last),
        .i_start_offset     (start_offset),
        .i_transfer_length  (transfer_length),
        .o_out_valid        (out_valid),
        .i_out_ready        (out_ready),
        .o_status           (status),
        .o_chunk_seg        (chunk_seg),
        .o_chunk_src_addr   (chunk_src_addr),
        .o_chunk_dst_offset (chunk_dst_offset),
        .o_chunk_len        (chunk_len),
        .o_last             (last)
    );

    sgrc_chunk_checker result_check (
        .i_clk              (clk),
        .i_rst_n            (rst_n),
        .i_in_valid         (in_valid),
        .i_in_ready         (in_ready),
        .i_req_type         (req_type),
        .i_seg_index        (seg_index),
        .i_seg_addr         (seg_addr),
        .i_seg_size         (seg_size),
        .i_seg_is_last      (seg_is_last),
        .i_start_offset     (start_offset),
        .i_transfer_length  (transfer_length),
        .i_out_valid        (out_valid),
        .i_out_ready        (out_ready),
        .i_status           (status),
        .i_chunk_seg        (chunk_seg),
        .i_chunk_src_addr   (chunk_src_addr),
        .i_chunk_dst_offset (chunk_dst_offset),
        .i_chunk_len        (chunk_len),
        .i_last             (last),
        .o_errors           (errors),
        .o_pending          (pending)
    );

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Result side: random stall per result, one long hold to back the block up
    // while the sender keeps offering requests.
    initial begin
        int stall_left;
        int taken;
        stall_left = 0;
        taken = 0;
        wait (rst_n);
        forever begin
            @(posedge clk);
            if (out_valid && out_ready) begin
                taken++;
                stall_left = no_idle ? 0 : $urandom_range(0, 9);
                if (taken == 80)
                    stall_left = LONG_HOLD;
            end
            if (stall_left > 0) begin
                out_ready <= 1'b0;
                stall_left--;
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    task automatic send_item(input logic req, input logic [3:0] idx,
                             input logic [31:0] addr, input logic [31:0] size,
                             input logic is_last, input logic [31:0] off,
                             input logic [31:0] len);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 9);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid        <= 1'b1;
        req_type        <= req;
        seg_index       <= idx;
        seg_addr        <= addr;
        seg_size        <= size;
        seg_is_last     <= is_last;
        start_offset    <= off;
        transfer_length <= len;
        do @(posedge clk); while (!in_ready);
        items_sent++;
    endtask

    task automatic load_seg(input logic [3:0] idx, input logic [31:0] addr,
                            input logic [31:0] size, input logic is_last);
        shadow_size[idx] = size;
        if (is_last)
            shadow_count = int'(idx) + 1;
        send_item(REQ_LOAD, idx, addr, size, is_last, $urandom, $urandom);
    endtask

    task automatic xfer(input logic [31:0] off, input logic [31:0] len);
        send_item(REQ_XFER, 4'($urandom), $urandom, $urandom, 1'($urandom), off, len);
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    function automatic longint unsigned table_bytes();
        longint unsigned sum;
        sum = 0;
        for (int k = 0; k < shadow_count; k++)
            sum += shadow_size[k];
        return sum;
    endfunction

    function automatic logic [31:0] pick_size();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10) return '0;
        if (r < 20) return $urandom;
        if (r < 25) return 32'hFFFF_FFFF;
        return $urandom_range(1, 200);
    endfunction

    function automatic logic [31:0] pick_addr();
        int r;
        r = $urandom_range(0, 3);
        if (r < 2) return $urandom;
        if (r == 2) return 32'hFFFF_FF00 + $urandom_range(0, 255);
        return $urandom_range(0, 255);
    endfunction

    // well_formed with a non-empty table: offset inside the buffer; otherwise past
    // the end, zero length or fully random fields
    task automatic rand_xfer(input bit well_formed);
        longint unsigned total;
        longint unsigned span;
        longint unsigned off64;
        longint unsigned prefix;
        logic [31:0]     len;
        int              r;
        int              j;

        total = table_bytes();
        span = (total > 64'hFFFF_FFFF) ? 64'h1_0000_0000 : total;
        r = $urandom_range(0, 99);
        if (!well_formed || total == 0) begin
            if (r < 40 && total <= 64'hFFFF_FFFF)
                xfer(32'(total + $urandom_range(0, 2)), $urandom_range(0, 100));
            else if (r < 70 && total != 0)
                xfer(32'({$urandom, $urandom} % span), '0);
            else
                xfer($urandom, $urandom);
            return;
        end

        if (r < 30) begin
            // land on a segment edge
            j = $urandom_range(0, shadow_count - 1);
            prefix = 0;
            for (int k = 0; k < j; k++)
                prefix += shadow_size[k];
            off64 = prefix;
            if ($urandom_range(0, 1) && shadow_size[j] != 0)
                off64 += shadow_size[j] - 1;
            if (off64 >= span)
                off64 = span - 1;
        end else begin
            off64 = {$urandom, $urandom} % span;
        end

        r = $urandom_range(0, 99);
        if (r < 5)
            len = '0;
        else if (r < 45)
            len = $urandom_range(1, 300);
        else if (r < 70)
            len = $urandom;
        else if (r < 85)
            len = 32'hFFFF_FFFF;
        else if (total - off64 <= 64'hFFFF_FFFF)
            len = 32'(total - off64);
        else
            len = $urandom;
        xfer(32'(off64), len);
    endtask

    initial begin
        longint unsigned total;
        int              r;
        int              n;
        bit              mid_drain_done;

        mid_drain_done = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // empty table: invalid wins over zero length
        xfer('0, 32'd100);
        xfer('0, '0);

        // full table: empty slots every fifth, one huge slot, address wrap in slots 3 and 7
        for (int k = 0; k < SEG_SLOTS; k++)
            load_seg(4'(k),
                     (k == 3) ? 32'hFFFF_FFF8 : (k == 7) ? 32'hFFFF_FFFF : 32'(k) << 24,
                     (k % 5 == 0) ? 32'd0 : (k == 14) ? 32'h8000_0000 : 32'(16 * k),
                     k == SEG_SLOTS - 1);
        total = table_bytes();
        xfer(32'd58, 32'd38);              // ends on the segment edge
        xfer(32'd58, 32'd39);              // spills into the next segment
        xfer('0, 32'hFFFF_FFFF);           // runs off the table end
        xfer(32'(total - 1), 32'd1);
        xfer(32'(total), 32'd5);           // one past the end
        xfer(32'd16, 32'd32);              // exactly one segment
        xfer(32'd20, '0);                  // zero length

        // shrink to a single empty segment, then a single full-size one
        load_seg('0, 32'h0000_0010, '0, 1'b1);
        xfer('0, 32'd1);
        load_seg('0, 32'hFFFF_FFF0, 32'hFFFF_FFFF, 1'b1);
        xfer(32'hFFFF_FFFE, 32'hFFFF_FFFF);

        drain_results();

        while (items_sent < ITEM_TARGET) begin
            no_idle = (items_sent >= 70 && items_sent < 95);
            if (items_sent >= 110 && !mid_drain_done) begin
                drain_results();
                mid_drain_done = 1'b1;
            end
            r = $urandom_range(0, 99);
            if (r < 25) begin
                n = $urandom_range(1, SEG_SLOTS);
                for (int k = 0; k < n; k++)
                    load_seg(4'(k), pick_addr(), pick_size(), k == n - 1);
                repeat ($urandom_range(2, 5)) rand_xfer(1'b1);
            end else if (r < 80) begin
                rand_xfer(1'b1);
            end else if (r < 90) begin
                load_seg(4'($urandom), pick_addr(), pick_size(), $urandom_range(0, 9) < 3);
            end else begin
                rand_xfer(1'b0);
            end
        end
        no_idle = 1'b0;

        drain_results();
        repeat (FLUSH_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

/* files.f */
rtl/sgrc_pkg.sv
rtl/sgrc_ram.sv
rtl/scatter_gather_read_chunker.sv
tb/sgrc_chunk_checker.sv
tb/scatter_gather_read_chunker_test.sv
